// ===== rtl/lbc_pkg.sv =====
// Shared opcode, status and state machine types for the block buffer cache tag store.
package lbc_pkg;

   // Operation carried by an input item.
   typedef enum logic [1:0] {
      OP_GET     = 2'd0,
      OP_RELEASE = 2'd1,
      OP_PIN     = 2'd2,
      OP_UNPIN   = 2'd3
   } opcode_type;

   // Status reported with every result item.
   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_NO_FREE   = 2'd1,
      STATUS_UNDERFLOW = 2'd2,
      STATUS_OVERFLOW  = 2'd3
   } status_type;

   // Sequencer states of the top level.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_GET_UPDATE,
      ST_SLOT_UPDATE,
      ST_MOVE,
      ST_FINISH
   } state_type;

endpackage

// ===== rtl/lbc_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module lbc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lru_block_buffer_cache.sv =====
// Get: a scan of the slot RAM with one read per slot, then an update of the chosen slot.
// Release that frees a slot: a read-modify-write sweep of the RAM moves ranks.
// Pin, unpin and other releases: an update of the slot read at acceptance; a slot index out of range skips it.
// One item is worked on at a time; the next is taken once the result sits in the output register.
// After reset a clearing pass writes every slot entry while req_stall stays high.
module lru_block_buffer_cache #(
   parameter int SLOTS      = 32,
   parameter int REF_BITS   = 8,
   parameter int BLOCK_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_device_id,
   input  logic [31:0] req_block_number,
   input  logic [4:0]  req_slot_index,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [4:0]  rsp_slot_out,
   output logic        rsp_hit,
   output logic        rsp_needs_read,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_ref_count_out
);

   localparam int AW    = $clog2(SLOTS);
   localparam int CNT_W = AW + 1;
   localparam logic [CNT_W-1:0]    CNT_END = CNT_W'(SLOTS);
   localparam logic [REF_BITS-1:0] REF_MAX = {REF_BITS{1'b1}};
   localparam logic [REF_BITS-1:0] REF_ONE = REF_BITS'(1);
   localparam logic [AW-1:0]       RANK_LAST = AW'(SLOTS - 1);

   // One slot entry as it is kept in the RAM.
   typedef struct packed {
      logic [7:0]            device;
      logic [BLOCK_BITS-1:0] block;
      logic                  valid;
      logic [REF_BITS-1:0]   refs;
      logic [AW-1:0]         rank;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // RAM ports.
   logic               ram_wr_en;
   logic [AW-1:0]      ram_wr_addr;
   entry_type          ram_wr_data;
   logic [AW-1:0]      ram_rd_addr;
   logic [ENTRY_W-1:0] ram_rd_data;
   entry_type          rd_entry;

   // Control registers.
   lbc_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic               data_vld_ff, data_vld_in;
   logic [AW-1:0]      data_addr_ff, data_addr_in;
   logic               rsp_valid_ff, rsp_valid_in;

   // Item registers.
   lbc_pkg::opcode_type   op_ff, op_in;
   logic [7:0]            dev_ff, dev_in;
   logic [BLOCK_BITS-1:0] blk_ff, blk_in;
   logic [AW-1:0]         idx_ff, idx_in;

   // Scan results: best match and best victim.
   logic          m_found_ff, m_found_in;
   logic [AW-1:0] m_slot_ff, m_slot_in;
   entry_type     m_entry_ff, m_entry_in;
   logic          v_found_ff, v_found_in;
   logic [AW-1:0] v_slot_ff, v_slot_in;
   logic [AW-1:0] v_rank_ff, v_rank_in;

   // Rank of the slot being made most recent.
   logic [AW-1:0] mv_rank_ff, mv_rank_in;

   // Pending result and output register.
   logic [4:0]           res_slot_ff, res_slot_in;
   logic                 res_hit_ff, res_hit_in;
   logic                 res_rd_ff, res_rd_in;
   lbc_pkg::status_type  res_status_ff, res_status_in;
   logic [7:0]           res_refs_ff, res_refs_in;
   logic [4:0]           out_slot_ff, out_slot_in;
   logic                 out_hit_ff, out_hit_in;
   logic                 out_rd_ff, out_rd_in;
   lbc_pkg::status_type  out_status_ff, out_status_in;
   logic [7:0]           out_refs_ff, out_refs_in;

   lbc_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_entry = ram_rd_data;

   // Control state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lbc_pkg::ST_CLEAR;
         cnt_ff       <= '0;
         data_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         data_vld_ff  <= data_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      data_addr_ff  <= data_addr_in;
      op_ff         <= op_in;
      dev_ff        <= dev_in;
      blk_ff        <= blk_in;
      idx_ff        <= idx_in;
      m_found_ff    <= m_found_in;
      m_slot_ff     <= m_slot_in;
      m_entry_ff    <= m_entry_in;
      v_found_ff    <= v_found_in;
      v_slot_ff     <= v_slot_in;
      v_rank_ff     <= v_rank_in;
      mv_rank_ff    <= mv_rank_in;
      res_slot_ff   <= res_slot_in;
      res_hit_ff    <= res_hit_in;
      res_rd_ff     <= res_rd_in;
      res_status_ff <= res_status_in;
      res_refs_ff   <= res_refs_in;
      out_slot_ff   <= out_slot_in;
      out_hit_ff    <= out_hit_in;
      out_rd_ff     <= out_rd_in;
      out_status_ff <= out_status_in;
      out_refs_ff   <= out_refs_in;
   end

   // Sequencer: next state, RAM accesses and result.
   always_comb begin
      logic      tag_eq;
      entry_type upd;

      state_in      = state_ff;
      cnt_in        = cnt_ff;
      data_vld_in   = 1'b0;
      op_in         = op_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      idx_in        = idx_ff;
      m_found_in    = m_found_ff;
      m_slot_in     = m_slot_ff;
      m_entry_in    = m_entry_ff;
      v_found_in    = v_found_ff;
      v_slot_in     = v_slot_ff;
      v_rank_in     = v_rank_ff;
      mv_rank_in    = mv_rank_ff;
      res_slot_in   = res_slot_ff;
      res_hit_in    = res_hit_ff;
      res_rd_in     = res_rd_ff;
      res_status_in = res_status_ff;
      res_refs_in   = res_refs_ff;
      out_slot_in   = out_slot_ff;
      out_hit_in    = out_hit_ff;
      out_rd_in     = out_rd_ff;
      out_status_in = out_status_ff;
      out_refs_in   = out_refs_ff;
      rsp_valid_in  = rsp_valid_ff & rsp_stall;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = data_addr_ff;
      ram_wr_data   = rd_entry;
      ram_rd_addr   = cnt_ff[AW-1:0];
      req_stall     = 1'b1;
      tag_eq        = (rd_entry.device == dev_ff) && (rd_entry.block == blk_ff);
      upd           = rd_entry;

      case (state_ff)
         // Write every entry with its reset value, one slot a cycle.
         lbc_pkg::ST_CLEAR: begin
            ram_wr_en        = 1'b1;
            ram_wr_addr      = cnt_ff[AW-1:0];
            ram_wr_data      = '0;
            ram_wr_data.rank = RANK_LAST - cnt_ff[AW-1:0];
            cnt_in           = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_END - CNT_W'(1)) begin
               state_in = lbc_pkg::ST_IDLE;
               cnt_in   = '0;
            end
         end

         // Take an item and start its RAM accesses.
         lbc_pkg::ST_IDLE: begin
            req_stall   = 1'b0;
            ram_rd_addr = AW'(req_slot_index);
            if (req_valid) begin
               op_in      = lbc_pkg::opcode_type'(req_opcode);
               dev_in     = req_device_id;
               blk_in     = BLOCK_BITS'(req_block_number);
               idx_in     = AW'(req_slot_index);
               m_found_in = 1'b0;
               v_found_in = 1'b0;
               cnt_in     = '0;
               res_hit_in = 1'b0;
               res_rd_in  = 1'b0;
               if (req_opcode == lbc_pkg::OP_GET) begin
                  state_in = lbc_pkg::ST_SCAN;
               end else if (32'(req_slot_index) >= SLOTS) begin
                  // A slot beyond the pool is echoed and ignored.
                  res_slot_in   = req_slot_index;
                  res_status_in = lbc_pkg::STATUS_OK;
                  res_refs_in   = '0;
                  state_in      = lbc_pkg::ST_FINISH;
               end else begin
                  state_in = lbc_pkg::ST_SLOT_UPDATE;
               end
            end
         end

         // Read every slot; keep the most recent match and the least recent free slot.
         lbc_pkg::ST_SCAN: begin
            if (cnt_ff != CNT_END) begin
               data_vld_in = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
            if (data_vld_ff) begin
               if (tag_eq && (!m_found_ff || rd_entry.rank < m_entry_ff.rank)) begin
                  m_found_in = 1'b1;
                  m_slot_in  = data_addr_ff;
                  m_entry_in = rd_entry;
               end
               if (rd_entry.refs == '0 && (!v_found_ff || rd_entry.rank > v_rank_ff)) begin
                  v_found_in = 1'b1;
                  v_slot_in  = data_addr_ff;
                  v_rank_in  = rd_entry.rank;
               end
            end
            if (cnt_ff == CNT_END) begin
               state_in = lbc_pkg::ST_GET_UPDATE;
            end
         end

         // Apply the get to the chosen slot.
         lbc_pkg::ST_GET_UPDATE: begin
            state_in = lbc_pkg::ST_FINISH;
            if (m_found_ff) begin
               res_slot_in = 5'(m_slot_ff);
               res_hit_in  = 1'b1;
               if (m_entry_ff.refs == REF_MAX) begin
                  res_rd_in     = 1'b0;
                  res_status_in = lbc_pkg::STATUS_OVERFLOW;
                  res_refs_in   = 8'(m_entry_ff.refs);
               end else begin
                  upd           = m_entry_ff;
                  upd.refs      = m_entry_ff.refs + REF_ONE;
                  upd.valid     = 1'b1;
                  ram_wr_en     = 1'b1;
                  ram_wr_addr   = m_slot_ff;
                  ram_wr_data   = upd;
                  res_rd_in     = ~m_entry_ff.valid;
                  res_status_in = lbc_pkg::STATUS_OK;
                  res_refs_in   = 8'(upd.refs);
               end
            end else if (v_found_ff) begin
               // Recycle the victim under the new tag.
               upd.device    = dev_ff;
               upd.block     = blk_ff;
               upd.valid     = 1'b1;
               upd.refs      = REF_ONE;
               upd.rank      = v_rank_ff;
               ram_wr_en     = 1'b1;
               ram_wr_addr   = v_slot_ff;
               ram_wr_data   = upd;
               res_slot_in   = 5'(v_slot_ff);
               res_hit_in    = 1'b0;
               res_rd_in     = 1'b1;
               res_status_in = lbc_pkg::STATUS_OK;
               res_refs_in   = 8'(REF_ONE);
            end else begin
               res_slot_in   = '0;
               res_hit_in    = 1'b0;
               res_rd_in     = 1'b0;
               res_status_in = lbc_pkg::STATUS_NO_FREE;
               res_refs_in   = '0;
            end
         end

         // Release, pin or unpin on the entry read at acceptance.
         lbc_pkg::ST_SLOT_UPDATE: begin
            state_in    = lbc_pkg::ST_FINISH;
            res_slot_in = 5'(idx_ff);
            ram_wr_addr = idx_ff;
            if (op_ff == lbc_pkg::OP_PIN) begin
               if (rd_entry.refs == REF_MAX) begin
                  res_status_in = lbc_pkg::STATUS_OVERFLOW;
                  res_refs_in   = 8'(rd_entry.refs);
               end else begin
                  upd.refs      = rd_entry.refs + REF_ONE;
                  ram_wr_en     = 1'b1;
                  ram_wr_data   = upd;
                  res_status_in = lbc_pkg::STATUS_OK;
                  res_refs_in   = 8'(upd.refs);
               end
            end else if (rd_entry.refs == '0) begin
               res_status_in = lbc_pkg::STATUS_UNDERFLOW;
               res_refs_in   = '0;
            end else begin
               upd.refs      = rd_entry.refs - REF_ONE;
               ram_wr_en     = 1'b1;
               ram_wr_data   = upd;
               res_status_in = lbc_pkg::STATUS_OK;
               res_refs_in   = 8'(upd.refs);
               // A release that drops the last reference moves the slot to the front.
               if (op_ff == lbc_pkg::OP_RELEASE && upd.refs == '0) begin
                  mv_rank_in = rd_entry.rank;
                  cnt_in     = '0;
                  state_in   = lbc_pkg::ST_MOVE;
               end
            end
         end

         // Sweep the ranks: read one slot while writing back the one read before.
         lbc_pkg::ST_MOVE: begin
            if (cnt_ff != CNT_END) begin
               data_vld_in = 1'b1;
               cnt_in      = cnt_ff + CNT_W'(1);
            end
            if (data_vld_ff) begin
               if (data_addr_ff == idx_ff) begin
                  upd.rank = '0;
               end else if (rd_entry.rank < mv_rank_ff) begin
                  upd.rank = rd_entry.rank + AW'(1);
               end
               ram_wr_en   = 1'b1;
               ram_wr_data = upd;
            end
            if (cnt_ff == CNT_END) begin
               state_in = lbc_pkg::ST_FINISH;
            end
         end

         // Hand the result to the output register once it is free.
         lbc_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               out_slot_in   = res_slot_ff;
               out_hit_in    = res_hit_ff;
               out_rd_in     = res_rd_ff;
               out_status_in = res_status_ff;
               out_refs_in   = res_refs_ff;
               rsp_valid_in  = 1'b1;
               state_in      = lbc_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lbc_pkg::ST_IDLE;
         end
      endcase

      // Remember which slot the read issued this cycle returns.
      data_addr_in = ram_rd_addr;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot_out      = out_slot_ff;
   assign rsp_hit           = out_hit_ff;
   assign rsp_needs_read    = out_rd_ff;
   assign rsp_status        = out_status_ff;
   assign rsp_ref_count_out = out_refs_ff;

endmodule
